// ----- sv/ptd_pkg.sv -----
// ----------------------------------------------------------------------------
// ptd_pkg: shared types and codes of the priority task dispatcher
// Holds the request and result transaction layouts and the operation and
// status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptd_pkg;

    localparam int KEY_W   = 64;
    localparam int PRIO_W  = 8;
    localparam int BURST_W = 16;
    localparam int ID_W    = 8;
    localparam int TIME_W  = 32;

    // Operation codes
    localparam logic OP_ADD      = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_ADDED      = 2'd0;
    localparam logic [1:0] STATUS_FULL       = 2'd1;
    localparam logic [1:0] STATUS_DISPATCHED = 2'd2;
    localparam logic [1:0] STATUS_EMPTY      = 2'd3;

    typedef struct packed {
        logic               operation;
        logic [KEY_W-1:0]   name_key;
        logic [PRIO_W-1:0]  task_priority;
        logic [BURST_W-1:0] burst_length;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [ID_W-1:0]    task_id;
        logic [TIME_W-1:0]  run_start;
        logic [TIME_W-1:0]  run_end;
        logic [BURST_W-1:0] run_burst;
    } out_item_t;

endpackage

// ----- sv/priority_task_dispatcher.sv -----
// ----------------------------------------------------------------------------
// priority_task_dispatcher: non-preemptive priority dispatcher over a table
// Add: scans the table for the lowest free slot and reports full when none
// is free. Dispatch: reads every slot, one table read per cycle through one
// compare. The next accept can come in the cycle after the result commit.
// One transaction at a time; sync reset empties the table, zeroes time and
// id.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module priority_task_dispatcher #(
    parameter int MAX_TASKS = 32,
    parameter int KEY_BYTES = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ptd_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ptd_pkg::out_item_t  m_data
);

    localparam int KW    = 8 * KEY_BYTES;
    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(MAX_TASKS);

    typedef struct packed {
        logic [KW-1:0]               key;
        logic [ptd_pkg::PRIO_W-1:0]  prio;
        logic [ptd_pkg::BURST_W-1:0] burst;
        logic [ptd_pkg::ID_W-1:0]    id;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD_SCAN,
        ST_DISP_SCAN,
        ST_FINISH
    } state_t;

    // Control registers
    state_t                      state_reg, state_next;
    logic [MAX_TASKS-1:0]        valid_reg, valid_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        found_reg, found_next;
    logic                        probe_reg, probe_next;
    logic                        m_valid_reg, m_valid_next;
    logic [ptd_pkg::TIME_W-1:0]  time_reg, time_next;
    logic [ptd_pkg::ID_W-1:0]    next_id_reg, next_id_next;

    // Payload registers
    ptd_pkg::in_item_t           req_reg, req_next;
    ptd_pkg::out_item_t          m_data_reg, m_data_next;
    logic [IDX_W-1:0]            slot_reg, slot_next;
    logic [IDX_W-1:0]            probe_idx_reg, probe_idx_next;
    logic                        probe_live_reg, probe_live_next;
    entry_t                      best_reg, best_next;

    // Task table
    entry_t                      table_mem [MAX_TASKS];
    entry_t                      rd_data_reg;
    logic                        mem_we;
    logic                        rd_en;
    entry_t                      wr_data;

    logic [IDX_W-1:0]            cnt_idx;
    logic                        out_free;
    logic [ptd_pkg::TIME_W:0]    finish_sum;
    logic [ptd_pkg::TIME_W-1:0]  finish_sat;
    logic                        better;

    assign cnt_idx  = cnt_reg[IDX_W-1:0];
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Saturating finish time of the selected task
    assign finish_sum = {1'b0, time_reg}
                      + {{(ptd_pkg::TIME_W + 1 - ptd_pkg::BURST_W){1'b0}}, best_reg.burst};
    assign finish_sat = finish_sum[ptd_pkg::TIME_W] ? '1 : finish_sum[ptd_pkg::TIME_W-1:0];

    // Comparator: higher priority wins, then smaller key
    assign better = !found_reg
                 || (rd_data_reg.prio > best_reg.prio)
                 || ((rd_data_reg.prio == best_reg.prio) && (rd_data_reg.key < best_reg.key));

    assign wr_data = '{key:   req_reg.name_key[ptd_pkg::KEY_W-1 -: KW],
                       prio:  req_reg.task_priority,
                       burst: req_reg.burst_length,
                       id:    next_id_reg};

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        cnt_next        = cnt_reg;
        found_next      = found_reg;
        probe_next      = probe_reg;
        m_valid_next    = m_valid_reg;
        time_next       = time_reg;
        next_id_next    = next_id_reg;
        req_next        = req_reg;
        m_data_next     = m_data_reg;
        slot_next       = slot_reg;
        probe_idx_next  = probe_idx_reg;
        probe_live_next = probe_live_reg;
        best_next       = best_reg;
        mem_we          = 1'b0;
        rd_en           = 1'b0;

        // Drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next   = s_data;
                    cnt_next   = '0;
                    found_next = 1'b0;
                    probe_next = 1'b0;
                    state_next = (s_data.operation == ptd_pkg::OP_ADD) ? ST_ADD_SCAN
                                                                        : ST_DISP_SCAN;
                end
            end

            ST_ADD_SCAN: begin
                // Look for the lowest free slot, one per cycle
                if (cnt_reg == CNT_END) begin
                    state_next = ST_FINISH;
                end else if (!valid_reg[cnt_idx]) begin
                    found_next = 1'b1;
                    slot_next  = cnt_idx;
                    state_next = ST_FINISH;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_DISP_SCAN: begin
                // Compare the entry read last cycle against the best so far
                if (probe_reg && probe_live_reg && better) begin
                    found_next = 1'b1;
                    slot_next  = probe_idx_reg;
                    best_next  = rd_data_reg;
                end
                // Issue the next table read
                if (cnt_reg != CNT_END) begin
                    rd_en           = 1'b1;
                    probe_next      = 1'b1;
                    probe_idx_next  = cnt_idx;
                    probe_live_next = valid_reg[cnt_idx];
                    cnt_next        = cnt_reg + 1'b1;
                end else begin
                    probe_next = 1'b0;
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH: begin
                // Hold until the result register is free, then commit
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    state_next   = ST_IDLE;
                    if (req_reg.operation == ptd_pkg::OP_ADD) begin
                        if (found_reg) begin
                            mem_we                = 1'b1;
                            valid_next[slot_reg]  = 1'b1;
                            m_data_next.status    = ptd_pkg::STATUS_ADDED;
                            m_data_next.task_id   = next_id_reg;
                            next_id_next          = next_id_reg + 1'b1;
                        end else begin
                            m_data_next.status = ptd_pkg::STATUS_FULL;
                        end
                    end else begin
                        if (found_reg) begin
                            valid_next[slot_reg]   = 1'b0;
                            m_data_next.status     = ptd_pkg::STATUS_DISPATCHED;
                            m_data_next.task_id    = best_reg.id;
                            m_data_next.run_start  = time_reg;
                            m_data_next.run_end    = finish_sat;
                            m_data_next.run_burst  = best_reg.burst;
                            time_next              = finish_sat;
                        end else begin
                            m_data_next.status = ptd_pkg::STATUS_EMPTY;
                        end
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            cnt_reg     <= '0;
            found_reg   <= 1'b0;
            probe_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            time_reg    <= '0;
            next_id_reg <= '0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            cnt_reg     <= cnt_next;
            found_reg   <= found_next;
            probe_reg   <= probe_next;
            m_valid_reg <= m_valid_next;
            time_reg    <= time_next;
            next_id_reg <= next_id_next;
        end
        req_reg        <= req_next;
        m_data_reg     <= m_data_next;
        slot_reg       <= slot_next;
        probe_idx_reg  <= probe_idx_next;
        probe_live_reg <= probe_live_next;
        best_reg       <= best_next;
    end

    // Task table: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            table_mem[slot_reg] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= table_mem[cnt_idx];
        end
    end

    // Assertions
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("dispatcher ready right after accepting a transaction");

    a_time_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (time_reg >= $past(time_reg)))
        else $error("running time went backwards");

    a_empty_means_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg.status == ptd_pkg::STATUS_EMPTY)) |-> (valid_reg == '0))
        else $error("empty status reported with valid entries in the table");

    a_dispatch_removes_one: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_FINISH) && out_free && found_reg
         && (req_reg.operation == ptd_pkg::OP_DISPATCH))
        |=> ($countones(valid_reg) == $past($countones(valid_reg)) - 1))
        else $error("dispatch did not remove exactly one entry");

    a_finish_after_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.run_end >= m_data_reg.run_start))
        else $error("finish time precedes start time");

endmodule
